// ----- rtl/core/data_block_bitmap_allocator_core_defines.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef DATA_BLOCK_BITMAP_ALLOCATOR_CORE_DEFINES_SVH
`define DATA_BLOCK_BITMAP_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define DBBA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// next-cycle implication, disabled in reset
`define DBBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`else

`define DBBA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DBBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/dbba_pkg.sv -----
// Shared constants and types of the data block bitmap allocator.
package dbba_pkg;

    localparam int POOL_BLOCKS_DEF = 1024;
    localparam int MAP_BITS        = 32;
    localparam int BLOCK_W         = 13;
    localparam int FDB_W           = 12;
    localparam int STATUS_W        = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_NO_FREE       = 3'd1,
        ST_PROTECTED     = 3'd2,
        ST_OUT_OF_BOUNDS = 3'd3,
        ST_ALREADY_FREE  = 3'd4
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

endpackage

// ----- rtl/core/dbba_if.sv -----
// Handshake channel interfaces: request, response and config write.
interface dbba_req_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [dbba_pkg::BLOCK_W-1:0] block_in;

    modport source (output valid, output op, output block_in, input ready);
    modport sink   (input valid, input op, input block_in, output ready);
endinterface

interface dbba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dbba_pkg::STATUS_W-1:0] status;
    logic [dbba_pkg::BLOCK_W-1:0]  block_out;

    modport source (output valid, output status, output block_out, input ready);
    modport sink   (input valid, input status, input block_out, output ready);
endinterface

interface dbba_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [dbba_pkg::FDB_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/dbba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dbba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/data_block_bitmap_allocator_core.sv -----
// Top level of the data block bitmap allocator.
//
//  channel | dir | words carried               | completes when
//  --------+-----+-----------------------------+----------------------
//  req     | in  | op, block_in                | req.valid & req.ready
//  rsp     | out | status, block_out           | rsp.valid & rsp.ready
//  cfg     | in  | data -> first_data_block    | cfg.valid & cfg.ready
//
//  Allocate: a word-at-a-time scan of the bitmap RAM that reads the next word
//  while the previous one is tested; the lowest free bit found is taken.
//  Free: read, test, write back; range errors go straight to done.
//  One request is worked at a time; req.ready is high in idle, also while a
//  finished response still sits in the output register.
//  Reset clears a per-word valid bit so every word reads as all free; no
//  clearing pass. rsp stalls hold the response register and keep a new result in done.
`include "data_block_bitmap_allocator_core_defines.svh"

module data_block_bitmap_allocator_core #(
    parameter int POOL_BLOCKS = dbba_pkg::POOL_BLOCKS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    dbba_req_if.sink        req,
    dbba_rsp_if.source      rsp,
    dbba_cfg_if.sink        cfg
);

    localparam int MAP_WORDS = (POOL_BLOCKS + dbba_pkg::MAP_BITS - 1) / dbba_pkg::MAP_BITS;
    localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int LAST_BITS = POOL_BLOCKS - dbba_pkg::MAP_BITS * (MAP_WORDS - 1);
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);
    // bits past the pool end in the last word read as used
    localparam logic [31:0] TAIL_MASK =
        (LAST_BITS == 32) ? 32'h0 : ~((32'h1 << LAST_BITS) - 32'h1);
    localparam int BW = dbba_pkg::BLOCK_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_CHK,
        S_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic [dbba_pkg::FDB_W-1:0]  fdb_reg;
    logic [MAP_WORDS-1:0]        valid_reg, valid_next;
    logic [WORD_W-1:0]           rd_idx_reg, rd_idx_next;
    logic                        rd_more_reg, rd_more_next;
    logic [WORD_W-1:0]           chk_idx_reg, chk_idx_next;
    logic                        chk_live_reg, chk_live_next;
    logic [4:0]                  bit_reg, bit_next;
    dbba_pkg::status_t           res_status_reg, res_status_next;
    logic [BW-1:0]               res_block_reg, res_block_next;
    logic                        out_valid_reg, out_valid_next;
    dbba_pkg::status_t           out_status_reg, out_status_next;
    logic [BW-1:0]               out_block_reg, out_block_next;

    // bitmap RAM ports
    logic                        ram_we, ram_re;
    logic [WORD_W-1:0]           ram_waddr, ram_raddr;
    logic [31:0]                 ram_wdata, ram_rdata;

    // effective word under test and its lowest free bit
    logic [31:0]                 word_eff;
    logic                        zero_found;
    logic [4:0]                  zero_pos;

    // free-request range checks
    logic [BW:0]                 pool_end;
    logic [BW-1:0]               slot_in;
    logic                        is_prot, is_oob;
    logic                        can_load;

    dbba_ram #(
        .WIDTH (dbba_pkg::MAP_BITS),
        .DEPTH (MAP_WORDS),
        .ADDR_W(WORD_W)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.block_out = out_block_reg;

    assign can_load = !out_valid_reg || rsp.ready;

    // never-written words read as all free
    always_comb
    begin
        word_eff = valid_reg[chk_idx_reg] ? ram_rdata : 32'h0;
        if (chk_idx_reg == LAST_WORD)
        begin
            word_eff = word_eff | TAIL_MASK;
        end
    end

    // lowest zero bit
    always_comb
    begin
        zero_found = 1'b0;
        zero_pos   = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!word_eff[i])
            begin
                zero_found = 1'b1;
                zero_pos   = 5'(i);
            end
        end
    end

    assign pool_end = {1'b0, 1'b0, fdb_reg} + (BW+1)'(POOL_BLOCKS);
    assign slot_in  = req.block_in - {1'b0, fdb_reg};
    assign is_prot  = req.block_in < {1'b0, fdb_reg};
    assign is_oob   = {1'b0, req.block_in} >= pool_end;

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        rd_idx_next     = rd_idx_reg;
        rd_more_next    = rd_more_reg;
        chk_idx_next    = chk_idx_reg;
        chk_live_next   = chk_live_reg;
        bit_next        = bit_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_block_next  = out_block_reg;
        ram_we    = 1'b0;
        ram_waddr = chk_idx_reg;
        ram_wdata = word_eff;
        ram_re    = 1'b0;
        ram_raddr = rd_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_block_next = '0;
                    if (req.op == dbba_pkg::OP_ALLOC)
                    begin
                        rd_idx_next   = '0;
                        rd_more_next  = 1'b1;
                        chk_live_next = 1'b0;
                        state_next    = S_SCAN;
                    end
                    else if (is_prot)
                    begin
                        res_status_next = dbba_pkg::ST_PROTECTED;
                        state_next      = S_DONE;
                    end
                    else if (is_oob)
                    begin
                        res_status_next = dbba_pkg::ST_OUT_OF_BOUNDS;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        chk_idx_next = slot_in[5 +: WORD_W];
                        bit_next     = slot_in[4:0];
                        state_next   = S_FREE_RD;
                    end
                end
            end

            S_SCAN:
            begin
                // issue the next word while the previous one is tested
                if (rd_more_reg)
                begin
                    ram_re        = 1'b1;
                    chk_idx_next  = rd_idx_reg;
                    chk_live_next = 1'b1;
                    rd_more_next  = (rd_idx_reg != LAST_WORD);
                    if (rd_idx_reg != LAST_WORD)
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
                if (chk_live_reg)
                begin
                    if (zero_found)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = word_eff | (32'h1 << zero_pos);
                        valid_next[chk_idx_reg] = 1'b1;
                        res_status_next = dbba_pkg::ST_OK;
                        res_block_next  = BW'({chk_idx_reg, zero_pos}) + {1'b0, fdb_reg};
                        state_next      = S_DONE;
                    end
                    else if (chk_idx_reg == LAST_WORD)
                    begin
                        res_status_next = dbba_pkg::ST_NO_FREE;
                        state_next      = S_DONE;
                    end
                end
            end

            S_FREE_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = chk_idx_reg;
                state_next = S_FREE_CHK;
            end

            S_FREE_CHK:
            begin
                if (!word_eff[bit_reg])
                begin
                    res_status_next = dbba_pkg::ST_ALREADY_FREE;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = word_eff & ~(32'h1 << bit_reg);
                    valid_next[chk_idx_reg] = 1'b1;
                    res_status_next = dbba_pkg::ST_OK;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_block_next  = res_block_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fdb_reg       <= '0;
            valid_reg     <= '0;
            rd_more_reg   <= 1'b0;
            chk_live_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            rd_more_reg   <= rd_more_next;
            chk_live_reg  <= chk_live_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                fdb_reg <= cfg.data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        chk_idx_reg    <= chk_idx_next;
        bit_reg        <= bit_next;
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        out_status_reg <= out_status_next;
        out_block_reg  <= out_block_next;
    end

    // a new response only comes out of the done state
    `DBBA_ASSERT_IMPL(a_rsp_from_done, clk, rst_n, $rose(out_valid_reg), $past(state_reg == S_DONE))
    // failed requests never carry a block number
    `DBBA_ASSERT_IMPL(a_err_zero_block, clk, rst_n, out_valid_reg && (out_status_reg != dbba_pkg::ST_OK), out_block_reg == '0)
    // scan read-ahead never hits the word being written back
    `DBBA_ASSERT_IMPL(a_no_rw_collide, clk, rst_n, ram_we && ram_re, ram_waddr != ram_raddr)
    // an accepted request leaves idle
    `DBBA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req.valid && req.ready, state_reg != S_IDLE)

endmodule

// ----- sim/data_block_bitmap_allocator_core_tb.sv -----
// Self-checking testbench for the data block bitmap allocator core.
`timescale 1ns / 100ps

module data_block_bitmap_allocator_core_tb;

    localparam int MAP_BITS = dbba_pkg::MAP_BITS;
    localparam int BLOCK_W  = dbba_pkg::BLOCK_W;
    localparam int FDB_W    = dbba_pkg::FDB_W;
    localparam int STATUS_W = dbba_pkg::STATUS_W;

    // Pool geometry matches the default build of the block.
    localparam int POOL      = dbba_pkg::POOL_BLOCKS_DEF;
    localparam int MAP_WORDS = (POOL + MAP_BITS - 1) / MAP_BITS;
    localparam int BLOCK_MAX = (1 << BLOCK_W) - 1;
    localparam int FDB_MAX   = (1 << FDB_W) - 1;

    // Longest stretch of cycles with no word moving on any channel. A slow
    // but correct run sees at most a sender gap, a full allocate scan and a
    // receiver stall back to back; this is far above that.
    localparam int STALL_LIMIT = 2000;

    // Grace period after the last response, a little above the worst scan.
    localparam int TAIL_CYCLES = 40;

    localparam int SIDE_REQ = 0;
    localparam int SIDE_RSP = 1;

    typedef struct {
        dbba_pkg::status_t    status;
        logic [BLOCK_W-1:0]   block;
    } alloc_result_t;

    // Tracks the bitmap and the start block, predicts one response per
    // accepted request and checks responses in order.
    class alloc_scoreboard;
        bit [MAP_BITS-1:0] used_map [MAP_WORDS];
        bit [FDB_W-1:0]    first_block;
        int                used_count;
        alloc_result_t     expected [$];
        int                accepted;
        int                errors;
        int                status_seen [5];

        function bit slot_used(int slot);
            return used_map[slot / MAP_BITS][slot % MAP_BITS];
        endfunction

        function void mark_slot(int slot, bit used);
            used_map[slot / MAP_BITS][slot % MAP_BITS] = used;
            used_count += used ? 1 : -1;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        // Random block number whose slot is used (or free); caller makes
        // sure one exists.
        function bit [BLOCK_W-1:0] pick_block(bit want_used);
            int slot;
            slot = $urandom_range(0, POOL - 1);
            while (slot_used(slot) != want_used)
                slot = (slot + 1) % POOL;
            return BLOCK_W'(slot + first_block);
        endfunction

        // Prediction for one accepted request word.
        function void note_request(dbba_pkg::op_t op, bit [BLOCK_W-1:0] blk);
            alloc_result_t res;
            int            slot;
            res.status = dbba_pkg::ST_OK;
            res.block  = '0;
            if (op == dbba_pkg::OP_ALLOC)
            begin
                // first fit: lowest free slot
                slot = -1;
                for (int s = 0; s < POOL && slot < 0; s++)
                    if (!slot_used(s))
                        slot = s;
                if (slot < 0)
                    res.status = dbba_pkg::ST_NO_FREE;
                else
                begin
                    mark_slot(slot, 1'b1);
                    res.block = BLOCK_W'(slot + first_block);
                end
            end
            else if (blk < first_block)
                res.status = dbba_pkg::ST_PROTECTED;
            else if (int'(blk) >= int'(first_block) + POOL)
                res.status = dbba_pkg::ST_OUT_OF_BOUNDS;
            else
            begin
                slot = int'(blk) - int'(first_block);
                if (!slot_used(slot))
                    res.status = dbba_pkg::ST_ALREADY_FREE;
                else
                    mark_slot(slot, 1'b0);
            end
            expected.push_back(res);
            accepted++;
        endfunction

        // Compare one accepted response word with the oldest prediction.
        function void check_result(logic [STATUS_W-1:0] got_status,
                                   logic [BLOCK_W-1:0] got_block);
            alloc_result_t want;
            if (expected.size() == 0)
            begin
                $display("%0t: response with nothing expected, actual status %0d block %0d",
                         $time, got_status, got_block);
                errors++;
                return;
            end
            want = expected.pop_front();
            status_seen[int'(want.status)]++;
            if (got_status !== want.status)
            begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, want.status, got_status);
                errors++;
            end
            if (got_block !== want.block)
            begin
                $display("%0t: block_out mismatch, expected %0d actual %0d",
                         $time, want.block, got_block);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dbba_req_if req_ch ();
    dbba_rsp_if rsp_ch ();
    dbba_cfg_if cfg_ch ();

    data_block_bitmap_allocator_core #(
        .POOL_BLOCKS (POOL)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    alloc_scoreboard sb = new();

    // Idle pattern state per side: runs of words either all back to back
    // or with random gaps.
    int run_left [2];
    bit calm     [2];
    int start_settings;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Gap in cycles before the next word on one side.
    function automatic int draw_gap(int side);
        if (run_left[side] == 0)
        begin
            run_left[side] = $urandom_range(10, 60);
            calm[side]     = ($urandom_range(0, 3) == 0);
        end
        run_left[side]--;
        if (calm[side])
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // Present one request word after a random gap and hold it until taken.
    // Valid is left high afterward so back-to-back words need no toggle.
    task automatic send_request(dbba_pkg::op_t op, bit [BLOCK_W-1:0] blk);
        int gap;
        gap = draw_gap(SIDE_REQ);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.block_in <= blk;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        sb.note_request(op, blk);
        @(negedge clk);
    endtask

    // Stop sending and wait until every predicted response has come back.
    task automatic wait_for_idle();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write first_data_block; only called with the block idle.
    task automatic write_first_block(bit [FDB_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        sb.first_block = value;
        start_settings++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One random request. alloc_pct of words allocate, free_pct free a block
    // in use; the rest are error cases or any 13-bit number.
    task automatic issue_mixed(int alloc_pct, int free_pct);
        int               pick;
        dbba_pkg::op_t    op;
        bit [BLOCK_W-1:0] blk;
        pick = $urandom_range(0, 99);
        op   = dbba_pkg::OP_FREE;
        blk  = BLOCK_W'($urandom_range(0, BLOCK_MAX));    // junk payload on allocate too
        if (pick < alloc_pct)
            op = dbba_pkg::OP_ALLOC;
        else if (pick < alloc_pct + free_pct)
        begin
            if (sb.used_count > 0)
                blk = sb.pick_block(1'b1);
            else
                op = dbba_pkg::OP_ALLOC;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: if (sb.used_count < POOL) blk = sb.pick_block(1'b0);
                1: if (sb.first_block > 0)
                       blk = BLOCK_W'($urandom_range(0, sb.first_block - 1));
                2: blk = BLOCK_W'($urandom_range(int'(sb.first_block) + POOL, BLOCK_MAX));
                default: ;
            endcase
        end
        // now and then let the pipe run dry before the next word
        if ($urandom_range(0, 49) == 0)
            wait_for_idle();
        send_request(op, blk);
    endtask

    // Response side: random ready stalls, check every accepted word.
    initial
    begin
        int gap;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(SIDE_RSP);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready));
            sb.check_result(rsp_ch.status, rsp_ch.block_out);
            @(negedge clk);
        end
    end

    // Watchdog: any word on any channel resets the count.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus
    initial
    begin
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.op       = dbba_pkg::OP_ALLOC;
        req_ch.block_in = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        start_settings  = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, start block 0: first-fit order, refill of a hole,
        // double free, last pool slot, first slot past the end, top number.
        write_first_block('0);
        send_request(dbba_pkg::OP_ALLOC, '0);                  // -> 0
        send_request(dbba_pkg::OP_ALLOC, BLOCK_W'(BLOCK_MAX)); // -> 1, payload ignored
        send_request(dbba_pkg::OP_ALLOC, '0);                  // -> 2
        send_request(dbba_pkg::OP_FREE, 13'd1);
        send_request(dbba_pkg::OP_FREE, 13'd1);                // already free
        send_request(dbba_pkg::OP_ALLOC, '0);                  // hole at 1 reused
        send_request(dbba_pkg::OP_FREE, 13'd0);
        send_request(dbba_pkg::OP_FREE, BLOCK_W'(POOL - 1));   // last slot, free
        send_request(dbba_pkg::OP_FREE, BLOCK_W'(POOL));       // one past the end
        send_request(dbba_pkg::OP_FREE, BLOCK_W'(BLOCK_MAX));
        send_request(dbba_pkg::OP_ALLOC, '0);                  // -> 0 again

        // Directed, start block at its top: bitmap kept, slots now read
        // against the new start; protected checked ahead of bounds.
        wait_for_idle();
        write_first_block(FDB_W'(FDB_MAX));
        send_request(dbba_pkg::OP_FREE, 13'd0);
        send_request(dbba_pkg::OP_FREE, BLOCK_W'(FDB_MAX - 1));
        send_request(dbba_pkg::OP_FREE, BLOCK_W'(FDB_MAX + POOL));
        send_request(dbba_pkg::OP_FREE, BLOCK_W'(BLOCK_MAX));
        send_request(dbba_pkg::OP_FREE, BLOCK_W'(FDB_MAX));           // slot 0 in use
        send_request(dbba_pkg::OP_FREE, BLOCK_W'(FDB_MAX));           // now already free
        send_request(dbba_pkg::OP_FREE, BLOCK_W'(FDB_MAX + POOL - 1)); // last slot, free
        send_request(dbba_pkg::OP_ALLOC, '0);
        send_request(dbba_pkg::OP_ALLOC, '0);

        // Fill the whole pool with a little churn, then hit it while full.
        wait_for_idle();
        write_first_block(FDB_W'($urandom_range(1, FDB_MAX - 1)));
        while (sb.used_count < POOL)
            issue_mixed(90, 5);
        repeat (15)
            issue_mixed(100, 0);

        // Drain heavy, then balanced mixes under several start blocks.
        wait_for_idle();
        write_first_block(FDB_W'($urandom_range(1, FDB_MAX - 1)));
        repeat (250)
            issue_mixed(20, 60);

        wait_for_idle();
        write_first_block(FDB_W'(FDB_MAX));
        repeat (150)
            issue_mixed(50, 35);

        wait_for_idle();
        write_first_block('0);
        repeat (150)
            issue_mixed(45, 40);

        wait_for_idle();
        write_first_block(FDB_W'($urandom_range(1, FDB_MAX - 1)));
        repeat (150)
            issue_mixed(50, 30);

        // Everything back, then a short quiet window for strays.
        wait_for_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d responses never arrived", $time, sb.pending());
            sb.errors++;
        end

        $display("Ran %0d requests over %0d start-block settings, pool filled to %0d of %0d.",
                 sb.accepted, start_settings, POOL, POOL);
        $display("Responses: ok %0d, no free %0d, protected %0d, out of bounds %0d, "
                 , sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3]);
        $display("already free %0d, mismatches %0d.", sb.status_seen[4], sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
